// ===== hdl/bencode_scalar_token_parser_unit_macros.svh =====
// Assertion macros for the bencode scalar token parser.
// Used by the top level only; needs nothing else.
`ifndef BENCODE_SCALAR_TOKEN_PARSER_UNIT_MACROS_SVH
`define BENCODE_SCALAR_TOKEN_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSTP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bstp: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BSTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bstp: next-cycle check failed");

`endif

// ===== hdl/bstp_pkg.sv =====
// Shared types and constants for the bencode scalar token parser.
// No dependencies; imported by bstp_scalar_fsm, bstp_out_reg and the top level.
`default_nettype none

package bstp_pkg;

  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERR   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_EMPTY     = 3'd0,
    ERR_NO_INT_END = 3'd1,
    ERR_BAD_INT   = 3'd2,
    ERR_NO_COLON  = 3'd3,
    ERR_LEN_RANGE = 3'd4,
    ERR_SHORT     = 3'd5,
    ERR_BAD_LEAD  = 3'd6,
    ERR_CONTAINER = 3'd7
  } err_e;

  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam int unsigned ValueW = 64;
  localparam int unsigned TdataOutW = 80;

  typedef struct packed {
    kind_e              kind;
    logic signed [63:0] int_value;
    logic [7:0]         string_byte;
    logic               string_last;
    err_e               error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/bstp_in_stage.sv =====
// Input register stage: captures one command/byte beat per cycle while it is free (empty, or its content is taken).
// Depends on nothing but the clock and reset.
`default_nettype none

module bstp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       in_cmd_i,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       take_i,
  output logic            item_valid_o,
  output logic            item_cmd_o,
  output logic [7:0]      item_byte_o
);

  logic       vld_q, vld_d;
  logic       cmd_q;
  logic [7:0] byte_q;

  // The register frees up in the same cycle its content is taken.
  assign in_ready_o = !vld_q || take_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q  <= in_cmd_i;
      byte_q <= in_byte_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_cmd_o   = cmd_q;
  assign item_byte_o  = byte_q;

endmodule

`default_nettype wire

// ===== hdl/bstp_scalar_fsm.sv =====
// Parser state and the per-byte step logic for integers and strings.
// Depends on bstp_pkg for codes, characters and the result type.
`default_nettype none

module bstp_scalar_fsm
  import bstp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       cmd_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_INT_START = 3'd1;
  localparam logic [2:0] PH_INT_DIGIT = 3'd2;
  localparam logic [2:0] PH_INT_SKIP  = 3'd3;
  localparam logic [2:0] PH_LEN_DIGIT = 3'd4;
  localparam logic [2:0] PH_LEN_SKIP  = 3'd5;
  localparam logic [2:0] PH_PAYLOAD   = 3'd6;
  localparam logic [2:0] PH_ERROR     = 3'd7;

  localparam int unsigned WideW = ValueW + 4;
  localparam logic [WideW-1:0] LenLimit = (WideW'(1) << LENGTH_BITS) - WideW'(1);
  localparam logic [WideW-1:0] IntMax   = WideW'(64'h7FFF_FFFF_FFFF_FFFF);

  logic [2:0]        phase_q, phase_d;
  // The accumulator doubles as the payload down-counter once ':' is seen.
  logic [ValueW-1:0] acc_q, acc_d;
  logic              neg_q, neg_d;
  logic              digits_q, digits_d;
  logic              bad_q, bad_d;
  logic              seen_q, seen_d;

  logic              is_digit;
  logic [3:0]        digit;
  logic              int_phase;
  logic [WideW-1:0]  limit;
  logic [WideW-1:0]  acc_wide;
  logic [WideW-1:0]  next_val;
  logic              over;

  assign is_digit  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit     = byte_i[3:0];
  assign int_phase = (phase_q == PH_INT_START) || (phase_q == PH_INT_DIGIT) ||
                     (phase_q == PH_INT_SKIP);
  assign limit     = int_phase ? (IntMax + WideW'(neg_q)) : LenLimit;
  assign acc_wide  = WideW'(acc_q);
  // acc * 10 + d, kept wide enough that it cannot wrap.
  assign next_val  = (acc_wide << 3) + (acc_wide << 1) + WideW'(digit);
  assign over      = next_val > limit;

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    digits_d    = digits_q;
    bad_d       = bad_q;
    seen_d      = seen_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i && cmd_i) begin
      phase_d  = PH_IDLE;
      acc_d    = '0;
      neg_d    = 1'b0;
      digits_d = 1'b0;
      bad_d    = 1'b0;
      seen_d   = 1'b0;
      res_o.kind = KIND_ERR;
      case (phase_q)
        PH_IDLE: begin
          res_valid_o      = !seen_q;
          res_o.error_code = ERR_EMPTY;
        end
        PH_INT_START, PH_INT_DIGIT, PH_INT_SKIP: begin
          res_valid_o      = 1'b1;
          res_o.error_code = ERR_NO_INT_END;
        end
        PH_LEN_DIGIT, PH_LEN_SKIP: begin
          res_valid_o      = 1'b1;
          res_o.error_code = ERR_NO_COLON;
        end
        PH_PAYLOAD: begin
          res_valid_o      = 1'b1;
          res_o.error_code = ERR_SHORT;
        end
        default: begin
          res_o = '0;
        end
      endcase
    end else if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          seen_d   = 1'b1;
          acc_d    = '0;
          neg_d    = 1'b0;
          digits_d = 1'b0;
          bad_d    = 1'b0;
          if (byte_i == CH_I) begin
            phase_d = PH_INT_START;
          end else if ((byte_i == CH_L) || (byte_i == CH_D)) begin
            phase_d          = PH_ERROR;
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERR;
            res_o.error_code = ERR_CONTAINER;
          end else if (is_digit) begin
            // A single digit is taken without a range check; it fits any length field of at least four bits.
            acc_d    = ValueW'(digit);
            digits_d = 1'b1;
            phase_d  = PH_LEN_DIGIT;
          end else begin
            phase_d          = PH_ERROR;
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_ERR;
            res_o.error_code = ERR_BAD_LEAD;
          end
        end
        PH_INT_START, PH_INT_DIGIT, PH_INT_SKIP: begin
          if (byte_i == CH_E) begin
            res_valid_o = 1'b1;
            if (!digits_q || bad_q) begin
              phase_d          = PH_ERROR;
              res_o.kind       = KIND_ERR;
              res_o.error_code = ERR_BAD_INT;
            end else begin
              phase_d         = PH_IDLE;
              res_o.kind      = KIND_INT;
              res_o.int_value = neg_q ? -acc_q : acc_q;
            end
          end else if ((phase_q == PH_INT_START) && (byte_i == CH_MINUS)) begin
            neg_d   = 1'b1;
            phase_d = PH_INT_DIGIT;
          end else if ((phase_q != PH_INT_SKIP) && is_digit) begin
            digits_d = 1'b1;
            if (!bad_q) begin
              if (over) begin
                bad_d = 1'b1;
              end else begin
                acc_d = next_val[ValueW-1:0];
              end
            end
            phase_d = PH_INT_DIGIT;
          end else begin
            phase_d = PH_INT_SKIP;
          end
        end
        PH_LEN_DIGIT, PH_LEN_SKIP: begin
          if (byte_i == CH_COLON) begin
            if (bad_q) begin
              phase_d          = PH_ERROR;
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_ERR;
              res_o.error_code = ERR_LEN_RANGE;
            end else if (acc_q == '0) begin
              phase_d     = PH_IDLE;
              res_valid_o = 1'b1;
              res_o.kind  = KIND_EMPTY;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end else if ((phase_q == PH_LEN_DIGIT) && is_digit) begin
            digits_d = 1'b1;
            if (!bad_q) begin
              if (over) begin
                bad_d = 1'b1;
              end else begin
                acc_d = next_val[ValueW-1:0];
              end
            end
          end else begin
            phase_d = PH_LEN_SKIP;
          end
        end
        PH_PAYLOAD: begin
          acc_d             = acc_q - ValueW'(1);
          res_valid_o       = 1'b1;
          res_o.kind        = KIND_BYTE;
          res_o.string_byte = byte_i;
          res_o.string_last = (acc_q == ValueW'(1));
          if (acc_q == ValueW'(1)) begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          // Error recovery: bytes are dropped until end of buffer.
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      digits_q <= 1'b0;
      bad_q    <= 1'b0;
      seen_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      digits_q <= digits_d;
      bad_q    <= bad_d;
      seen_q   <= seen_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bstp_out_reg.sv =====
// Result register holding one result beat until the sink takes it.
// Depends on bstp_pkg for the result type.
`default_nettype none

module bstp_out_reg
  import bstp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire logic    res_valid_i,
  input  wire result_t res_i,
  input  wire logic    out_ready_i,
  output logic         free_o,
  output logic         out_valid_o,
  output result_t      out_res_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = res_valid_i;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

// ===== hdl/bencode_scalar_token_parser_unit.sv =====
// Channel   | Dir | tdata (low bit up)                          | tuser / tlast
// s_axis    | in  | data_byte[7:0]                              | tuser: cmd
// m_axis    | out | int_value, string_byte, error_code, 5 zeros | tuser: kind; tlast: last
//
// Each byte beat is first captured in the input register, which feeds the step logic; the step's result
// is loaded into the output register when that register is free. A new beat is taken every cycle while
// the sink keeps up.
// Reset returns the parser to idle with an empty buffer; no clearing pass is needed.
// A stalled sink holds the result register; the input register still takes one beat.
// Top level of the bencode scalar token parser.
// Depends on bstp_pkg, bstp_in_stage, bstp_scalar_fsm, bstp_out_reg and the macro header.
`default_nettype none
`include "bencode_scalar_token_parser_unit_macros.svh"

module bencode_scalar_token_parser_unit
  import bstp_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [7:0]           s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [0:0]           s_axis_tuser_i,   // [0] cmd
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [TdataOutW-1:0]      m_axis_tdata_o,   // [63:0] int_value, [71:64]
                                                      // string_byte, [74:72] error_code
  output logic [1:0]                m_axis_tuser_o,   // [1:0] kind
  output logic                      m_axis_tlast_o    // string_last
);

  logic       item_valid;
  logic       item_cmd;
  logic [7:0] item_byte;
  logic       out_free;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign fire = item_valid && out_free;

  bstp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i[0]),
    .in_byte_i    (s_axis_tdata_i),
    .take_i       (fire),
    .item_valid_o (item_valid),
    .item_cmd_o   (item_cmd),
    .item_byte_o  (item_byte)
  );

  bstp_scalar_fsm #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (fire),
    .cmd_i       (item_cmd),
    .byte_i      (item_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bstp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_ready_i (m_axis_tready_i),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata_o = {5'b0, out_res.error_code, out_res.string_byte, out_res.int_value};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.string_last;

  // Only payload bytes may close a string.
  `BSTP_ASSERT_SAME(a_last_only_bytes, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != KIND_BYTE), !m_axis_tlast_o)
  // The integer field is zero unless the result is an integer.
  `BSTP_ASSERT_SAME(a_int_zero, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != KIND_INT), m_axis_tdata_o[63:0] == 64'd0)
  // A held input beat is not lost while the result side is blocked.
  `BSTP_ASSERT_NEXT(a_item_held, clk_i, rst_ni, item_valid && !out_free, item_valid)

endmodule

`default_nettype wire

// ===== tb/sv/tb_bencode_scalar_token_parser_unit.sv =====
// Self-checking testbench for the bencode scalar token parser unit.
// Needs bstp_pkg and the unit itself; drives byte beats and checks every result beat against
// a cycle-free predictor of the parser, or against the typed result of a directed row.
module tb_bencode_scalar_token_parser_unit;
  import bstp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LenBits = 32;
  localparam logic [63:0] LenLimit = (64'd1 << LenBits) - 64'd1;
  localparam logic [63:0] IntMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOB  = 1'b1;
  localparam int unsigned RandomBeats = 1150;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INT_START, ST_INT_DIGIT, ST_INT_SKIP,
    ST_LEN_DIGIT, ST_LEN_SKIP, ST_PAYLOAD, ST_ERROR
  } parse_phase_e;

  typedef struct packed {
    logic    cmd;
    logic [7:0] data;
    logic    typed;
    result_t want;
  } dir_row_t;

  localparam result_t ResNone      = '{KIND_INT, 64'sd0, 8'h00, 1'b0, ERR_EMPTY};
  localparam result_t ResEmptyBuf  = '{KIND_ERR, 64'sd0, 8'h00, 1'b0, ERR_EMPTY};
  localparam result_t ResIntMinus7 = '{KIND_INT, -64'sd7, 8'h00, 1'b0, ERR_EMPTY};
  localparam result_t ResEmptyStr  = '{KIND_EMPTY, 64'sd0, 8'h00, 1'b0, ERR_EMPTY};
  localparam result_t ResContainer = '{KIND_ERR, 64'sd0, 8'h00, 1'b0, ERR_CONTAINER};
  localparam result_t ResBadLead   = '{KIND_ERR, 64'sd0, 8'h00, 1'b0, ERR_BAD_LEAD};
  localparam result_t ResNoIntEnd  = '{KIND_ERR, 64'sd0, 8'h00, 1'b0, ERR_NO_INT_END};
  localparam result_t ResNoColon   = '{KIND_ERR, 64'sd0, 8'h00, 1'b0, ERR_NO_COLON};
  localparam result_t ResShort     = '{KIND_ERR, 64'sd0, 8'h00, 1'b0, ERR_SHORT};

  // Rows without a typed result are checked against the predictor.
  localparam dir_row_t DirRows [25] = '{
    '{CMD_EOB,  8'h00,    1'b1, ResEmptyBuf},
    '{CMD_BYTE, CH_I,     1'b0, ResNone},
    '{CMD_BYTE, CH_MINUS, 1'b0, ResNone},
    '{CMD_BYTE, "7",      1'b0, ResNone},
    '{CMD_BYTE, CH_E,     1'b1, ResIntMinus7},
    '{CMD_BYTE, CH_ZERO,  1'b0, ResNone},
    '{CMD_BYTE, CH_COLON, 1'b1, ResEmptyStr},
    '{CMD_BYTE, "2",      1'b0, ResNone},
    '{CMD_BYTE, CH_COLON, 1'b0, ResNone},
    '{CMD_BYTE, 8'h00,    1'b0, ResNone},
    '{CMD_BYTE, 8'hFF,    1'b0, ResNone},
    '{CMD_BYTE, CH_L,     1'b1, ResContainer},
    '{CMD_EOB,  8'hFF,    1'b0, ResNone},
    '{CMD_BYTE, 8'hFF,    1'b1, ResBadLead},
    '{CMD_EOB,  8'h00,    1'b0, ResNone},
    '{CMD_BYTE, CH_I,     1'b0, ResNone},
    '{CMD_BYTE, "5",      1'b0, ResNone},
    '{CMD_EOB,  8'h00,    1'b1, ResNoIntEnd},
    '{CMD_BYTE, "3",      1'b0, ResNone},
    '{CMD_BYTE, "x",      1'b0, ResNone},
    '{CMD_EOB,  8'h00,    1'b1, ResNoColon},
    '{CMD_BYTE, "2",      1'b0, ResNone},
    '{CMD_BYTE, CH_COLON, 1'b0, ResNone},
    '{CMD_BYTE, "a",      1'b0, ResNone},
    '{CMD_EOB,  8'h00,    1'b1, ResShort}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [7:0]           s_axis_tdata_i = 8'h00;
  logic [0:0]           s_axis_tuser_i = CMD_BYTE;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [TdataOutW-1:0] m_axis_tdata_o;
  logic [1:0]           m_axis_tuser_o;
  logic                 m_axis_tlast_o;

  // Predictor state.
  parse_phase_e ph;
  logic [63:0]  acc;
  logic         neg;
  logic         digits;
  logic         bad;
  logic [63:0]  remaining;
  logic         seen;

  result_t     expected_tokens [$];
  logic [7:0]  token_bytes [$];
  int unsigned mismatches;
  int unsigned live_beats;
  bit          no_gaps;
  bit          close_early;

  bencode_scalar_token_parser_unit #(
    .LENGTH_BITS(LenBits)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o,
    .m_axis_tlast_o
  );

  always #6 clk_i = ~clk_i;

  function automatic void clear_parser();
    ph = ST_IDLE;
    acc = 64'd0;
    neg = 1'b0;
    digits = 1'b0;
    bad = 1'b0;
    remaining = 64'd0;
    seen = 1'b0;
  endfunction

  function automatic void take_digit(input logic [7:0] c, input logic [63:0] limit);
    logic [63:0] d;
    d = {56'd0, 8'(c - CH_ZERO)};
    digits = 1'b1;
    if (bad) return;
    if (acc > (limit - d) / 64'd10) bad = 1'b1;
    else acc = acc * 64'd10 + d;
  endfunction

  // Advances the parser by one beat; returns 1 when the beat yields a result.
  function automatic bit parse_beat(input logic cmd, input logic [7:0] c,
                                    output result_t r);
    logic [63:0]  lim;
    logic         is_dig;
    parse_phase_e was;
    logic         had_lead;
    r = ResNone;
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    lim = IntMax + (neg ? 64'd1 : 64'd0);
    if (cmd == CMD_EOB) begin
      was = ph;
      had_lead = seen;
      clear_parser();
      r.kind = KIND_ERR;
      case (was)
        ST_IDLE: begin
          if (had_lead) return 1'b0;
          r.error_code = ERR_EMPTY;
        end
        ST_INT_START, ST_INT_DIGIT, ST_INT_SKIP: r.error_code = ERR_NO_INT_END;
        ST_LEN_DIGIT, ST_LEN_SKIP: r.error_code = ERR_NO_COLON;
        ST_PAYLOAD: r.error_code = ERR_SHORT;
        default: return 1'b0;
      endcase
      return 1'b1;
    end
    case (ph)
      ST_IDLE: begin
        seen = 1'b1;
        acc = 64'd0;
        neg = 1'b0;
        digits = 1'b0;
        bad = 1'b0;
        if (c == CH_I) begin
          ph = ST_INT_START;
          return 1'b0;
        end
        r.kind = KIND_ERR;
        if (c == CH_L || c == CH_D) begin
          ph = ST_ERROR;
          r.error_code = ERR_CONTAINER;
          return 1'b1;
        end
        if (is_dig) begin
          take_digit(c, LenLimit);
          ph = ST_LEN_DIGIT;
          return 1'b0;
        end
        ph = ST_ERROR;
        r.error_code = ERR_BAD_LEAD;
        return 1'b1;
      end
      ST_INT_START, ST_INT_DIGIT, ST_INT_SKIP: begin
        if (c == CH_E) begin
          if (!digits || bad) begin
            ph = ST_ERROR;
            r.kind = KIND_ERR;
            r.error_code = ERR_BAD_INT;
            return 1'b1;
          end
          ph = ST_IDLE;
          r.int_value = neg ? 64'd0 - acc : acc;
          return 1'b1;
        end
        if (ph == ST_INT_START && c == CH_MINUS) begin
          neg = 1'b1;
          ph = ST_INT_DIGIT;
        end else if (ph != ST_INT_SKIP && is_dig) begin
          take_digit(c, lim);
          ph = ST_INT_DIGIT;
        end else begin
          ph = ST_INT_SKIP;
        end
        return 1'b0;
      end
      ST_LEN_DIGIT, ST_LEN_SKIP: begin
        if (c == CH_COLON) begin
          if (bad) begin
            ph = ST_ERROR;
            r.kind = KIND_ERR;
            r.error_code = ERR_LEN_RANGE;
            return 1'b1;
          end
          if (acc == 64'd0) begin
            ph = ST_IDLE;
            r.kind = KIND_EMPTY;
            return 1'b1;
          end
          remaining = acc;
          ph = ST_PAYLOAD;
          return 1'b0;
        end
        if (ph == ST_LEN_DIGIT && is_dig) take_digit(c, LenLimit);
        else ph = ST_LEN_SKIP;
        return 1'b0;
      end
      ST_PAYLOAD: begin
        remaining = remaining - 64'd1;
        if (remaining == 64'd0) ph = ST_IDLE;
        r.kind = KIND_BYTE;
        r.string_byte = c;
        r.string_last = (remaining == 64'd0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // A filler byte that is neither a digit nor the given terminator.
  function automatic logic [7:0] junk_byte(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CH_ZERO && b <= CH_NINE) || b == avoid);
    return b;
  endfunction

  function automatic void put_decimal(input logic [63:0] v);
    logic [7:0] digs [$];
    do begin
      digs.push_front(8'(v % 64'd10) + CH_ZERO);
      v = v / 64'd10;
    end while (v != 64'd0);
    foreach (digs[j]) token_bytes.push_back(digs[j]);
  endfunction

  function automatic void gen_integer();
    logic [63:0] mag;
    bit          minus;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    minus = $urandom_range(0, 1);
    token_bytes.push_back(CH_I);
    case (pick)
      0: begin minus = 1'b0; mag = IntMax; end
      1: begin minus = 1'b1; mag = IntMax + 64'd1; end
      2: begin minus = 1'b0; mag = IntMax + 64'd1; end
      3: mag = 64'hFFFF_FFFF_FFFF_FFFF;
      4: mag = {$urandom, $urandom};
      5, 7, 8, 9: mag = 64'($urandom_range(0, 9));
      default: mag = {$urandom, $urandom} >> $urandom_range(1, 63);
    endcase
    if (minus) token_bytes.push_back(CH_MINUS);
    // No digits at all, possibly with a repeated sign.
    if (pick == 6) begin
      if ($urandom_range(0, 1)) token_bytes.push_back(CH_MINUS);
      token_bytes.push_back(CH_E);
      return;
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) token_bytes.push_back(CH_ZERO);
    put_decimal(mag);
    if (pick == 3 && $urandom_range(0, 1)) token_bytes.push_back("9");
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) token_bytes.push_back(junk_byte(CH_E));
    end
    token_bytes.push_back(CH_E);
  endfunction

  function automatic void gen_string();
    logic [63:0] len;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 39);
    case (pick)
      0, 1, 2, 3, 4, 5: len = 64'd0;
      6, 7: len = LenLimit;
      8, 9: len = LenLimit + 64'd1 + 64'($urandom_range(0, 1000));
      10: len = 64'($urandom_range(40, 120));
      default: len = 64'($urandom_range(1, 8));
    endcase
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) token_bytes.push_back(CH_ZERO);
    put_decimal(len);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) token_bytes.push_back(junk_byte(CH_COLON));
    end
    token_bytes.push_back(CH_COLON);
    // The largest length cannot complete within the run, so one to three bytes go and the buffer is closed.
    if (len == LenLimit) begin
      n = $urandom_range(1, 3);
      close_early = 1'b1;
    end else if (len > LenLimit) begin
      n = 0;
    end else begin
      n = int'(len);
    end
    repeat (n) token_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic send_beat(input logic cmd, input logic [7:0] b, input logic typed,
                           input result_t want);
    result_t predicted;
    bit      produced;
    while (!no_gaps && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tuser_i <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (!(cmd == CMD_BYTE && ph == ST_ERROR)) live_beats++;
    produced = parse_beat(cmd, b, predicted);
    if (typed) expected_tokens.push_back(want);
    else if (produced) expected_tokens.push_back(predicted);
  endtask

  function automatic void report(input string what, input result_t want,
                                 input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%t %s: want kind %0d val %0d byte %02h last %0b err %0d",
               $realtime, what, want.kind, want.int_value, want.string_byte,
               want.string_last, want.error_code);
      $display("%t %s: got  kind %0d val %0d byte %02h last %0b err %0d",
               $realtime, what, got.kind, got.int_value, got.string_byte,
               got.string_last, got.error_code);
    end
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got.kind = kind_e'(m_axis_tuser_o);
    got.int_value = m_axis_tdata_o[63:0];
    got.string_byte = m_axis_tdata_o[71:64];
    got.string_last = m_axis_tlast_o;
    got.error_code = err_e'(m_axis_tdata_o[74:72]);
    if (expected_tokens.size() == 0) begin
      report("unexpected beat", ResNone, got);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind !== want.kind || got.int_value !== want.int_value ||
        got.string_byte !== want.string_byte || got.string_last !== want.string_last ||
        got.error_code !== want.error_code) begin
      report("mismatch", want, got);
    end
  endfunction

  // Result side: sample the handshake before this edge's updates, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) check_result();
    m_axis_tready_i <= no_gaps || ($urandom_range(0, 99) >= 32);
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned n_tokens;
    int unsigned sel;
    int unsigned keep;
    int unsigned k;
    clear_parser();
    mismatches = 0;
    live_beats = 0;
    no_gaps = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirRows[i]) send_beat(DirRows[i].cmd, DirRows[i].data, DirRows[i].typed,
                                   DirRows[i].want);

    // Buffers of mostly well-formed tokens; an error or a cut token closes the buffer.
    live_beats = 0;
    while (live_beats < RandomBeats) begin
      no_gaps = (live_beats >= 400 && live_beats < 560);
      n_tokens = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      for (k = 0; k < n_tokens && ph != ST_ERROR; k++) begin
        token_bytes.delete();
        close_early = 1'b0;
        sel = $urandom_range(0, 99);
        if (sel < 45) gen_integer();
        else if (sel < 88) gen_string();
        else if (sel < 94) begin
          logic [7:0] b;
          do b = junk_byte(CH_I);
          while (b == CH_L || b == CH_D);
          token_bytes.push_back(b);
        end else begin
          token_bytes.push_back($urandom_range(0, 1) ? CH_L : CH_D);
        end
        if (token_bytes.size() > 1 && $urandom_range(0, 19) == 0) begin
          keep = $urandom_range(1, token_bytes.size() - 1);
          while (token_bytes.size() > keep) void'(token_bytes.pop_back());
          close_early = 1'b1;
        end
        foreach (token_bytes[j]) send_beat(CMD_BYTE, token_bytes[j], 1'b0, ResNone);
        if (close_early) break;
      end
      if (ph == ST_ERROR) begin
        repeat ($urandom_range(0, 3)) begin
          send_beat(CMD_BYTE, 8'($urandom_range(0, 255)), 1'b0, ResNone);
        end
      end
      send_beat(CMD_EOB, 8'($urandom_range(0, 255)), 1'b0, ResNone);
    end
    s_axis_tvalid_i <= 1'b0;
    no_gaps = 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bstp_pkg.sv
hdl/bstp_in_stage.sv
hdl/bstp_scalar_fsm.sv
hdl/bstp_out_reg.sv
hdl/bencode_scalar_token_parser_unit.sv
tb/sv/tb_bencode_scalar_token_parser_unit.sv
